### rtl/esp_pkg.sv
// Shared types and constants for the ellipsoid slice painter.
// No dependencies; imported by the front end, back end and top level.
`default_nettype none

package esp_pkg;

   // Control and status register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROT_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PAINT   = 3'd7;

   // Paint modes
   localparam logic MODE_FILL    = 1'b0;
   localparam logic MODE_OUTLINE = 1'b1;

   // Field width within packed registers
   localparam int FLD_W = 16;

   // Datapath widths. Inside the bounding box |dx|,|dy| <= maxR + 15 < 2^17
   // and |dz| <= maxR < 2^16, so these widths hold every value that matters.
   localparam int D_W    = 18;   // dx, dy kept after the box test
   localparam int DZ_W   = 17;   // dz kept after the slice test
   localparam int PROD_W = 34;   // Q1.14 entry times Q.4 offset
   localparam int SUM_W  = 36;   // sum of three products, Q.18
   localparam int MAG_W  = 20;   // rounded magnitude, Q.4
   localparam int SQ_W   = 2 * MAG_W;       // squared magnitude, Q.8
   localparam int TERM_W = SQ_W + FLD_W;    // times inverse square, Q.24
   localparam int Q_W    = TERM_W + 2;      // sum of three terms

   // Thresholds in Q.24
   localparam logic [Q_W-1:0] Q_ONE     = Q_W'(16777216);
   localparam logic [Q_W-1:0] Q_BAND_LO = Q_W'(15938356);
   localparam logic [Q_W-1:0] Q_BAND_HI = Q_W'(17616076);

   // Shift from Q.18 to Q.4; it also sets the rounding offset
   localparam int RND_SHIFT = 14;

   // Register file contents handed to the front and back ends
   typedef struct packed {
      logic [47:0] rot_x;
      logic [47:0] rot_y;
      logic [47:0] rot_z;
      logic [63:0] shape;
      logic [47:0] centre;
      logic [15:0] depth;
      logic        mode;
      logic [15:0] paint;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/esp_if.sv
// Valid/ready channel interfaces for pixel requests and painted responses.
// No dependencies; used by the front end, back end and top level.
`default_nettype none

interface esp_req_if #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_col;
   logic [COORD_BITS-1:0] pixel_row;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output pixel_col, output pixel_row, output pixel_in,
                   input ready);
   modport sink   (input valid, input pixel_col, input pixel_row, input pixel_in,
                   output ready);
endinterface

interface esp_rsp_if #(
   parameter int PIXEL_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  painted;

   modport source (output valid, output pixel_out, output painted, input ready);
   modport sink   (input valid, input pixel_out, input painted, output ready);
endinterface

`default_nettype wire

### rtl/esp_front.sv
// Front end: takes request words, forms centre offsets and the box test.
// Depends on esp_pkg and esp_req_if; feeds esp_queue.
`default_nettype none

module esp_front #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 16,
   parameter int ENTRY_W    = 1
) (
   input  wire                   clock,
   input  wire                   reset,
   esp_req_if.sink               req_bus,
   input  esp_pkg::cfg_type      cfg,
   output logic                  push_valid,
   output logic [ENTRY_W-1:0]    push_data,
   input  wire                   queue_full
);
   import esp_pkg::*;

   // Signed width wide enough for 16*col - cx and the box sums
   localparam int CW = ((COORD_BITS + 4 > FLD_W) ? COORD_BITS + 4 : FLD_W) + 3;

   logic                  valid_ff, valid_in;
   logic [ENTRY_W-1:0]    entry_ff;
   logic [ENTRY_W-1:0]    entry_in;
   logic                  take;

   logic signed [CW-1:0]  col_q, row_q, cx, cy, max_r;
   logic signed [CW-1:0]  dx, dy;
   logic signed [CW-1:0]  x_lo, x_hi, y_lo, y_hi;
   logic signed [D_W:0]   dz, z_lo, z_hi, mr_z;
   logic                  in_box;

   // Word taken when the stage is empty or about to drain into the queue
   assign req_bus.ready = !valid_ff || !queue_full;
   assign take          = req_bus.valid && req_bus.ready;

   // Offsets from the centre in Q.4
   always_comb begin
      col_q = $signed({{(CW-COORD_BITS-4){1'b0}}, req_bus.pixel_col, 4'b0000});
      row_q = $signed({{(CW-COORD_BITS-4){1'b0}}, req_bus.pixel_row, 4'b0000});
      cx    = $signed({{(CW-FLD_W){1'b0}}, cfg.centre[15:0]});
      cy    = $signed({{(CW-FLD_W){1'b0}}, cfg.centre[31:16]});
      max_r = $signed({{(CW-FLD_W){1'b0}}, cfg.shape[63:48]});
      dx    = col_q - cx;
      dy    = row_q - cy;
      dz    = $signed({3'b000, cfg.depth}) - $signed({3'b000, cfg.centre[47:32]});
      mr_z  = $signed({3'b000, cfg.shape[63:48]});

      // Box limits: -15 <= d + maxR and d - maxR <= 15 for dx, dy (no slack for dz), as sign tests
      x_lo = dx + max_r + CW'(15);
      x_hi = max_r + CW'(15) - dx;
      y_lo = dy + max_r + CW'(15);
      y_hi = max_r + CW'(15) - dy;
      z_lo = mr_z + dz;
      z_hi = mr_z - dz;

      in_box = !x_lo[CW-1] && !x_hi[CW-1] && !y_lo[CW-1] && !y_hi[CW-1]
            && !z_lo[D_W] && !z_hi[D_W];

      entry_in = {req_bus.pixel_in, in_box, dz[DZ_W-1:0], dy[D_W-1:0], dx[D_W-1:0]};
   end

   // Stage valid: loads on a take, holds while the queue is full
   assign valid_in = take || (valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_data  = entry_ff;

endmodule

`default_nettype wire

### rtl/esp_queue.sv
// Short register queue between the front and back ends.
// No dependencies; instantiated by the top level.
`default_nettype none

module esp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   input  wire [WIDTH-1:0]   push_data,
   output logic              full,
   output logic              head_valid,
   output logic [WIDTH-1:0]  head_data,
   input  wire               pop
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/esp_back.sv
// Back end: rotates offsets, evaluates the quadratic form and paints.
// Depends on esp_pkg and esp_rsp_if; fed from esp_queue.
`default_nettype none

module esp_back #(
   parameter int PIXEL_BITS = 16,
   parameter int ENTRY_W    = 1
) (
   input  wire                 clock,
   input  wire                 reset,
   input  esp_pkg::cfg_type    cfg,
   input  wire                 head_valid,
   input  wire [ENTRY_W-1:0]   head_data,
   output logic                pop,
   esp_rsp_if.source           rsp_bus
);
   import esp_pkg::*;

   localparam int STAGES = 5;

   // Stage valids, carried box flag and pixel
   logic [STAGES-1:0]     vld_ff, vld_in;
   logic                  box_ff [STAGES];
   logic [PIXEL_BITS-1:0] pix_ff [STAGES];
   logic                  adv;

   // Datapath registers
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic [MAG_W-1:0]         mag_ff [3];
   logic [MAG_W-1:0]         mag_in [3];
   logic [SQ_W-1:0]          sq_ff [3];
   logic [TERM_W-1:0]        term_ff [3];

   logic                     rsp_valid_ff;
   logic [PIXEL_BITS-1:0]    pixel_out_ff, pixel_out_in;
   logic                     painted_ff, painted_in;

   logic signed [D_W-1:0]    d [3];
   logic [47:0]              rows [3];
   logic [FLD_W-1:0]         inv_sq [3];
   logic signed [SUM_W-1:0]  abs_l;
   logic [SUM_W-1:0]         rnd;
   logic [Q_W-1:0]           q;
   logic                     hit;

   // Whole pipeline moves when the output register is free or draining
   assign adv = !rsp_valid_ff || rsp_bus.ready;
   assign pop = adv && head_valid;

   // Unpack the queue word and the configuration
   always_comb begin
      d[0]      = $signed(head_data[D_W-1:0]);
      d[1]      = $signed(head_data[2*D_W-1:D_W]);
      d[2]      = D_W'($signed(head_data[2*D_W+DZ_W-1:2*D_W]));
      rows[0]   = cfg.rot_x;
      rows[1]   = cfg.rot_y;
      rows[2]   = cfg.rot_z;
      inv_sq[0] = cfg.shape[15:0];
      inv_sq[1] = cfg.shape[31:16];
      inv_sq[2] = cfg.shape[47:32];
   end

   // Products of matrix entries and offsets
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int s = 0; s < 3; s++) begin
            prod_in[r][s] = $signed(rows[r][FLD_W*s +: FLD_W]) * d[s];
         end
      end
   end

   // Row sums, then magnitude rounded half away from zero to Q.4
   always_comb begin
      abs_l = '0;
      rnd   = '0;
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
      end
      for (int r = 0; r < 3; r++) begin
         abs_l     = sum_ff[r][SUM_W-1] ? -sum_ff[r] : sum_ff[r];
         rnd       = $unsigned(abs_l) + SUM_W'(1 << (RND_SHIFT - 1));
         mag_in[r] = rnd[RND_SHIFT +: MAG_W];
      end
   end

   // Quadratic form and paint decision
   always_comb begin
      q = Q_W'(term_ff[0]) + Q_W'(term_ff[1]) + Q_W'(term_ff[2]);
      unique case (cfg.mode)
         MODE_FILL:    hit = box_ff[STAGES-1] && (q <= Q_ONE);
         MODE_OUTLINE: hit = box_ff[STAGES-1] && (q >= Q_BAND_LO) && (q <= Q_BAND_HI);
         default:      hit = 1'b0;
      endcase
      painted_in   = hit;
      pixel_out_in = hit ? PIXEL_BITS'(cfg.paint) : pix_ff[STAGES-1];
   end

   assign vld_in = {vld_ff[STAGES-2:0], head_valid};

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   // Datapath, one step per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         box_ff[0] <= head_data[2*D_W+DZ_W];
         pix_ff[0] <= head_data[ENTRY_W-1 -: PIXEL_BITS];
         for (int k = 1; k < STAGES; k++) begin
            box_ff[k] <= box_ff[k-1];
            pix_ff[k] <= pix_ff[k-1];
         end
         for (int r = 0; r < 3; r++) begin
            for (int s = 0; s < 3; s++) begin
               prod_ff[r][s] <= prod_in[r][s];
            end
            sum_ff[r]  <= sum_in[r];
            mag_ff[r]  <= mag_in[r];
            sq_ff[r]   <= mag_ff[r] * mag_ff[r];
            term_ff[r] <= sq_ff[r] * inv_sq[r];
         end
         pixel_out_ff <= pixel_out_in;
         painted_ff   <= painted_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.pixel_out = pixel_out_ff;
   assign rsp_bus.painted   = painted_ff;

endmodule

`default_nettype wire

### rtl/ellipsoid_slice_painter.sv
// Ellipsoid slice painter: repaints the pixels of one z-slice that fall in a
// rotated triaxial ellipsoid (filled interior or a thin outline band).
//
// Channels: req_bus carries one pixel word (column, row, old value) with
// valid/ready; rsp_bus returns one word per request, in order, with the
// painted value and a painted flag. The csr_ port writes the eight
// registers (rotation rows, axis shape, centre, slice depth, mode, paint
// value); write them only while no pixel is in flight.
//
// Throughput: one pixel per cycle while the receiver is ready. Path: each
// word passes through the front register, the queue and the six-stage
// back-end pipeline (products, row sums, rounding, square, inverse-square
// scaling, compare).
//
// Reset zeroes the configuration and control registers, emptying the pipeline. When the
// receiver stalls, the back end holds, the four-word queue fills behind it
// and req_bus.ready then drops; no word is lost or repeated.
`default_nettype none

module ellipsoid_slice_painter #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   esp_req_if.sink                        req_bus,
   esp_rsp_if.source                      rsp_bus,
   input  wire                            csr_write_enable,
   input  wire [esp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [esp_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import esp_pkg::*;

   localparam int ENTRY_W     = PIXEL_BITS + 1 + DZ_W + 2 * D_W;
   localparam int QUEUE_DEPTH = 4;

   cfg_type              cfg_ff, cfg_in;
   logic                 push_valid;
   logic [ENTRY_W-1:0]   push_data;
   logic                 queue_full;
   logic                 head_valid;
   logic [ENTRY_W-1:0]   head_data;
   logic                 pop;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROT_X:  cfg_in.rot_x  = csr_write_data[47:0];
            CSR_ROT_Y:  cfg_in.rot_y  = csr_write_data[47:0];
            CSR_ROT_Z:  cfg_in.rot_z  = csr_write_data[47:0];
            CSR_SHAPE:  cfg_in.shape  = csr_write_data[63:0];
            CSR_CENTRE: cfg_in.centre = csr_write_data[47:0];
            CSR_DEPTH:  cfg_in.depth  = csr_write_data[15:0];
            CSR_MODE:   cfg_in.mode   = csr_write_data[0];
            CSR_PAINT:  cfg_in.paint  = csr_write_data[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: offsets and box test
   esp_front #(
      .COORD_BITS (COORD_BITS),
      .PIXEL_BITS (PIXEL_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Decoupling queue
   esp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // Back end: rotation, quadratic form, paint
   esp_back #(
      .PIXEL_BITS (PIXEL_BITS),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
